[rtl/core/ambient_light_lux_conversion_macros.svh]
// assertion helpers shared by the lux conversion files
`ifndef AMBIENT_LIGHT_LUX_CONVERSION_MACROS_SVH
`define AMBIENT_LIGHT_LUX_CONVERSION_MACROS_SVH

// same-cycle implication, off during reset
`define ALC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ALC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/alc_pkg.sv]
package alc_pkg;

  localparam int unsigned POWER_TABLE_ENTRIES = 256;
  localparam int unsigned QUEUE_DEPTH = 4;

  // saturation limits of the short and mid integration modes
  localparam logic [15:0] LIMIT_SHORT = 16'd5047;
  localparam logic [15:0] LIMIT_MID   = 16'd37177;

  // coefficients in q24
  localparam logic [19:0] K_A1 = 20'd510027;
  localparam logic [19:0] K_B1 = 20'd1040187;
  localparam logic [18:0] K_A2 = 19'd375810;
  localparam logic [18:0] K_B2 = 19'd520094;
  localparam logic [18:0] K_A3 = 19'd214748;
  localparam logic [18:0] K_B3 = 19'd256691;
  localparam logic [18:0] K_A4 = 19'd24495;
  localparam logic [18:0] K_B4 = 19'd18790;

  typedef enum logic [2:0] {
    MODE_HI_402 = 3'd0,
    MODE_HI_101 = 3'd1,
    MODE_HI_14  = 3'd2,
    MODE_LO_402 = 3'd3,
    MODE_LO_101 = 3'd4,
    MODE_LO_14  = 3'd5
  } mode_t;

  // which formula a word takes
  typedef enum logic [2:0] {
    REG_POW,
    REG_LIN2,
    REG_LIN3,
    REG_LIN4,
    REG_ZERO
  } region_t;

  typedef struct packed {
    logic        sat;
    region_t     region;
    logic [15:0] bb;
    logic [15:0] ir;
    logic [2:0]  mode;
  } word_t;

  // gain and integration scale in q16
  function automatic logic [24:0] mode_scale(logic [2:0] mode);
    logic [24:0] s;
    case (mode)
      MODE_HI_101: s = 25'd260063;
      MODE_HI_14:  s = 25'd1927529;
      MODE_LO_402: s = 25'd1048576;
      MODE_LO_101: s = 25'd4161016;
      MODE_LO_14:  s = 25'd30840471;
      default:     s = 25'd65536;
    endcase
    return s;
  endfunction

  // largest v with v^5 * den^7 <= i^7 * 2^80, i.e. 2^16 * (i/den)^1.4
  function automatic logic [15:0] pow_entry(int unsigned i, int unsigned den);
    logic [199:0] lhs;
    logic [199:0] rhs;
    logic [16:0]  lo;
    logic [16:0]  hi;
    logic [16:0]  mid;
    lo  = '0;
    hi  = 17'd65535;
    rhs = 200'd1;
    for (int k = 0; k < 7; k++) rhs = rhs * 200'(i);
    rhs = rhs << 80;
    while (lo < hi) begin
      mid = (lo + hi + 17'd1) >> 1;
      lhs = 200'd1;
      for (int k = 0; k < 5; k++) lhs = lhs * 200'(mid);
      for (int k = 0; k < 7; k++) lhs = lhs * 200'(den);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 17'd1;
    end
    return lo[15:0];
  endfunction

endpackage

[rtl/core/alc_front.sv]
module alc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [15:0]         broadband_count,
  input  logic [15:0]         infrared_count,
  input  logic [2:0]          mode,
  output logic                push,
  output alc_pkg::word_t      push_data,
  input  logic                full
);

  alc_pkg::word_t  word_next;
  alc_pkg::word_t  word;
  logic            word_valid;
  logic [15:0]     limit;
  logic            has_limit;

  // saturation limit of the mode
  always_comb begin
    limit     = alc_pkg::LIMIT_MID;
    has_limit = 1'b0;
    case (mode)
      alc_pkg::MODE_HI_101, alc_pkg::MODE_LO_101: begin
        limit     = alc_pkg::LIMIT_MID;
        has_limit = 1'b1;
      end
      alc_pkg::MODE_HI_14, alc_pkg::MODE_LO_14: begin
        limit     = alc_pkg::LIMIT_SHORT;
        has_limit = 1'b1;
      end
      default: has_limit = 1'b0;
    endcase
  end

  // classify by ratio with exact integer compares
  always_comb begin
    word_next.bb   = broadband_count;
    word_next.ir   = infrared_count;
    word_next.mode = mode;
    word_next.sat  = has_limit && (broadband_count > limit || infrared_count > limit);
    if (broadband_count == 16'd0) begin
      word_next.region = alc_pkg::REG_ZERO;
    end else if ({infrared_count, 1'b0} <= {1'b0, broadband_count}) begin
      word_next.region = alc_pkg::REG_POW;
    end else if (23'(infrared_count) * 23'd100 <= 23'(broadband_count) * 23'd61) begin
      word_next.region = alc_pkg::REG_LIN2;
    end else if (19'(infrared_count) * 19'd5 <= 19'(broadband_count) * 19'd4) begin
      word_next.region = alc_pkg::REG_LIN3;
    end else if (20'(infrared_count) * 20'd10 <= 20'(broadband_count) * 20'd13) begin
      word_next.region = alc_pkg::REG_LIN4;
    end else begin
      word_next.region = alc_pkg::REG_ZERO;
    end
  end

  assign sample_stall = word_valid && full;
  assign push         = word_valid && !full;
  assign push_data    = word;

  // front register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (!sample_stall) begin
      word_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall) begin
      word <= word_next;
    end
  end

endmodule

[rtl/core/alc_queue.sv]
`include "ambient_light_lux_conversion_macros.svh"

module alc_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = alc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] pop_data,
  output logic             head_valid
);

  localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0]   LastPtr  = PtrWidth'(Depth - 1);
  localparam logic [CountWidth-1:0] FullCnt  = CountWidth'(Depth);

  logic [Width-1:0]      mem [Depth];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [CountWidth-1:0] count;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign pop_data   = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrWidth'(1);
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrWidth'(1);
      if (push && !pop) count <= count + CountWidth'(1);
      else if (pop && !push) count <= count - CountWidth'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  `ALC_ASSERT_IMP(a_no_overflow, count == FullCnt, !push, "word pushed into full queue")
  `ALC_ASSERT_IMP(a_no_underflow, count == '0, !pop, "word popped from empty queue")

endmodule

[rtl/core/alc_back.sv]
`include "ambient_light_lux_conversion_macros.svh"

module alc_back #(
  parameter int unsigned PowerTableEntries = alc_pkg::POWER_TABLE_ENTRIES
) (
  input  logic            clk,
  input  logic            rst,
  input  alc_pkg::word_t  head,
  input  logic            head_valid,
  output logic            pop,
  output logic            result_valid,
  input  logic            result_stall,
  output logic [27:0]     lux_value,
  output logic            status_code
);

  localparam int unsigned IdxWidth = $clog2(PowerTableEntries + 1);
  localparam int unsigned NumWidth = 16 + $clog2(2 * PowerTableEntries + 1);
  localparam logic [NumWidth-1:0] TwoN = NumWidth'(2 * PowerTableEntries);
  localparam logic [IdxWidth-1:0] IdxMax = IdxWidth'(PowerTableEntries);
  localparam logic [35:0] A1Shifted = {alc_pkg::K_A1, 16'd0};

  typedef logic [15:0] pow_tab_t [PowerTableEntries+1];

  function automatic pow_tab_t build_pow_tab();
    pow_tab_t t;
    for (int i = 0; i <= int'(PowerTableEntries); i++) begin
      t[i] = alc_pkg::pow_entry(i, 2 * PowerTableEntries);
    end
    return t;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

  logic en;

  // divider pipeline for the table index, one quotient bit per stage
  logic                dv_v   [IdxWidth+1];
  alc_pkg::word_t      dv_w   [IdxWidth+1];
  logic [NumWidth-1:0] dv_rem [IdxWidth+1];
  logic [IdxWidth-1:0] dv_q   [IdxWidth+1];

  // later stages
  logic                tb_v;
  alc_pkg::word_t      tb_w;
  logic [15:0]         tb_entry;
  logic                m1_v;
  alc_pkg::word_t      m1_w;
  logic [35:0]         m1_b;
  logic [34:0]         m1_p;
  logic [34:0]         m1_q;
  logic                m2_v;
  alc_pkg::word_t      m2_w;
  logic [34:0]         m2_diff;
  logic [34:0]         m2_lin;
  logic                m3_v;
  logic                m3_sat;
  logic [2:0]          m3_mode;
  logic [34:0]         m3_raw;
  logic                m4_v;
  logic                m4_sat;
  logic [59:0]         m4_prod;
  logic [IdxWidth-1:0] idx;
  logic [18:0]         ca;
  logic [18:0]         cb;
  logic [50:0]         pow_prod;

  // whole back end advances unless the result is held
  assign en  = !(result_valid && result_stall);
  assign pop = head_valid && en;

  assign dv_v[0]   = head_valid;
  assign dv_w[0]   = head;
  assign dv_rem[0] = NumWidth'(head.ir) * TwoN;
  assign dv_q[0]   = '0;

  for (genvar k = 0; k < IdxWidth; k++) begin : g_div
    localparam int unsigned Bit = IdxWidth - 1 - k;
    logic [NumWidth-1:0] dsr;
    logic                ge;
    assign dsr = NumWidth'(dv_w[k].bb) << Bit;
    assign ge  = (dv_rem[k] >= dsr);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_w[k+1]   <= dv_w[k];
        dv_rem[k+1] <= ge ? dv_rem[k] - dsr : dv_rem[k];
        dv_q[k+1]   <= dv_q[k] | (IdxWidth'(ge) << Bit);
      end
    end
  end

  // clamp index and read power table
  assign idx = (dv_q[IdxWidth] > IdxMax) ? IdxMax : dv_q[IdxWidth];

  // coefficient pair of the linear formulas
  always_comb begin
    case (tb_w.region)
      alc_pkg::REG_LIN2: begin
        ca = alc_pkg::K_A2;
        cb = alc_pkg::K_B2;
      end
      alc_pkg::REG_LIN3: begin
        ca = alc_pkg::K_A3;
        cb = alc_pkg::K_B3;
      end
      alc_pkg::REG_LIN4: begin
        ca = alc_pkg::K_A4;
        cb = alc_pkg::K_B4;
      end
      default: begin
        ca = '0;
        cb = '0;
      end
    endcase
  end

  assign pow_prod = 51'(m2_w.bb) * 51'(m2_diff);

  // valid bits of the later stages
  always_ff @(posedge clk) begin
    if (rst) begin
      tb_v         <= 1'b0;
      m1_v         <= 1'b0;
      m2_v         <= 1'b0;
      m3_v         <= 1'b0;
      m4_v         <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      tb_v         <= dv_v[IdxWidth];
      m1_v         <= tb_v;
      m2_v         <= m1_v;
      m3_v         <= m2_v;
      m4_v         <= m3_v;
      result_valid <= m4_v;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      tb_w     <= dv_w[IdxWidth];
      tb_entry <= POW_TAB[idx];

      m1_w <= tb_w;
      m1_b <= 36'(alc_pkg::K_B1) * 36'(tb_entry);
      m1_p <= 35'(tb_w.bb) * 35'(ca);
      m1_q <= 35'(tb_w.ir) * 35'(cb);

      m2_w    <= m1_w;
      m2_diff <= (A1Shifted > m1_b) ? 35'(A1Shifted - m1_b) : '0;
      m2_lin  <= (m1_p > m1_q) ? m1_p - m1_q : '0;

      m3_sat  <= m2_w.sat;
      m3_mode <= m2_w.mode;
      case (m2_w.region)
        alc_pkg::REG_POW:  m3_raw <= pow_prod[50:16];
        alc_pkg::REG_LIN2, alc_pkg::REG_LIN3, alc_pkg::REG_LIN4: m3_raw <= m2_lin;
        default:           m3_raw <= '0;
      endcase

      m4_sat  <= m3_sat;
      m4_prod <= 60'(m3_raw) * 60'(alc_pkg::mode_scale(m3_mode));

      status_code <= m4_sat;
      lux_value   <= m4_sat ? '0 : m4_prod[59:32];
    end
  end

  `ALC_ASSERT_IMP(a_sat_zero, result_valid && status_code, lux_value == '0, "saturated word with lux")
  `ALC_ASSERT_IMP(a_idx_range, dv_v[IdxWidth] && dv_w[IdxWidth].region == alc_pkg::REG_POW, dv_q[IdxWidth] <= IdxMax, "power index beyond table")
  `ALC_ASSERT_NEXT(a_drain, m4_v && en, result_valid, "last stage word lost")

endmodule

[rtl/core/ambient_light_lux_conversion.sv]
// path from accept to result: front register, queue, one divider stage per index bit
//   (idx_bits = clog2(entries + 1)), table read, m1 to m4 stages and the result register
// throughput: one word per cycle when no result is held; one bit per divider stage
// a held result freezes the back end; the queue takes words until full
// reset: synchronous, active high; clears valid bits, queue and mode (mode 0)
module ambient_light_lux_conversion #(
  parameter int unsigned PowerTableEntries = alc_pkg::POWER_TABLE_ENTRIES,
  parameter int unsigned QueueDepth        = alc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_data,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic [15:0] broadband_count,
  input  logic [15:0] infrared_count,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [27:0] lux_value,
  output logic        status_code
);

  logic [2:0]     resolution_mode;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;
  alc_pkg::word_t push_data;
  alc_pkg::word_t head;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution_mode <= 3'd0;
    end else if (cfg_we) begin
      resolution_mode <= cfg_data;
    end
  end

  alc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .broadband_count (broadband_count),
    .infrared_count  (infrared_count),
    .mode            (resolution_mode),
    .push            (push),
    .push_data       (push_data),
    .full            (full)
  );

  alc_queue #(
    .Width ($bits(alc_pkg::word_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .pop_data   (head),
    .head_valid (head_valid)
  );

  alc_back #(
    .PowerTableEntries (PowerTableEntries)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .lux_value    (lux_value),
    .status_code  (status_code)
  );

endmodule

[sim/tb.sv]
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_data = '0;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  logic [15:0] broadband_count = '0;
  logic [15:0] infrared_count = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [27:0] lux_value;
  logic        status_code;

  typedef struct packed {
    logic [27:0] lux;
    logic        sat;
  } reading_t;

  reading_t    pending_readings[$];
  logic [15:0] power_curve[0:alc_pkg::POWER_TABLE_ENTRIES];
  logic [2:0]  active_mode = alc_pkg::MODE_HI_402;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          long_hold = 1'b0;
  bit          hold_taken = 1'b0;
  bit          failed = 1'b0;

  ambient_light_lux_conversion i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .broadband_count (broadband_count),
    .infrared_count  (infrared_count),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .lux_value       (lux_value),
    .status_code     (status_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ratio^1.4 curve, largest v with v^5 * den^7 <= i^7 * 2^80
  function automatic logic [15:0] curve_point(int unsigned i);
    logic [199:0] lhs, rhs, den;
    logic [16:0]  lo, hi, mid;
    den = 200'(2 * alc_pkg::POWER_TABLE_ENTRIES);
    lo = '0;
    hi = 17'd65535;
    rhs = 200'(i) ** 7;
    rhs = rhs << 80;
    while (lo < hi) begin
      mid = (lo + hi + 17'd1) >> 1;
      lhs = (200'(mid) ** 5) * (den ** 7);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 17'd1;
    end
    return lo[15:0];
  endfunction

  function automatic logic [63:0] gain_scale(logic [2:0] mode);
    case (mode)
      alc_pkg::MODE_HI_101: return 64'd260063;
      alc_pkg::MODE_HI_14:  return 64'd1927529;
      alc_pkg::MODE_LO_402: return 64'd1048576;
      alc_pkg::MODE_LO_101: return 64'd4161016;
      alc_pkg::MODE_LO_14:  return 64'd30840471;
      default:              return 64'd65536;
    endcase
  endfunction

  function automatic logic [63:0] linear_lux(logic [63:0] bb, logic [63:0] ir,
                                             logic [63:0] ca, logic [63:0] cb);
    logic [63:0] p, q;
    p = bb * ca;
    q = ir * cb;
    return (p > q) ? p - q : 64'd0;
  endfunction

  // expected reading for one count pair in the current mode
  function automatic reading_t predict_reading(logic [15:0] bbc, logic [15:0] irc);
    reading_t    r;
    logic [63:0] bb, ir, raw, lux, idx, a, b, lim;
    bit          has_lim;
    bb = 64'(bbc);
    ir = 64'(irc);
    raw = '0;
    has_lim = (active_mode == alc_pkg::MODE_HI_101 || active_mode == alc_pkg::MODE_LO_101 ||
               active_mode == alc_pkg::MODE_HI_14 || active_mode == alc_pkg::MODE_LO_14);
    lim = (active_mode == alc_pkg::MODE_HI_14 || active_mode == alc_pkg::MODE_LO_14) ?
          64'(alc_pkg::LIMIT_SHORT) : 64'(alc_pkg::LIMIT_MID);
    if (has_lim && (bb > lim || ir > lim)) begin
      r.lux = '0;
      r.sat = 1'b1;
      return r;
    end
    if (bb != 0) begin
      if (ir * 2 <= bb) begin
        idx = (64'(2 * alc_pkg::POWER_TABLE_ENTRIES) * ir) / bb;
        if (idx > alc_pkg::POWER_TABLE_ENTRIES) idx = alc_pkg::POWER_TABLE_ENTRIES;
        a = 64'd510027 << 16;
        b = 64'd1040187 * 64'(power_curve[idx]);
        raw = (a > b) ? (bb * (a - b)) >> 16 : 64'd0;
      end else if (ir * 100 <= bb * 61) begin
        raw = linear_lux(bb, ir, 64'd375810, 64'd520094);
      end else if (ir * 5 <= bb * 4) begin
        raw = linear_lux(bb, ir, 64'd214748, 64'd256691);
      end else if (ir * 10 <= bb * 13) begin
        raw = linear_lux(bb, ir, 64'd24495, 64'd18790);
      end
    end
    lux = (raw * gain_scale(active_mode)) >> 32;
    if (lux > 64'd268435455) lux = 64'd268435455;
    r.lux = lux[27:0];
    r.sat = 1'b0;
    return r;
  endfunction

  // send one word, holding it until accepted
  task automatic send_word(logic [15:0] bb, logic [15:0] ir);
    sample_valid <= 1'b1;
    broadband_count <= bb;
    infrared_count <= ir;
    pending_readings.push_back(predict_reading(bb, ir));
    do @(posedge clk); while (sample_stall);
  endtask

  task automatic idle_sender(int n);
    sample_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_readings();
    sample_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mode(logic [2:0] mode);
    drain_readings();
    cfg_we <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_mode = mode;
  endtask

  // random pair, biased toward each formula region and the limits
  task automatic random_word();
    logic [15:0] bb, ir;
    bb = 16'($urandom);
    case ($urandom_range(0, 7))
      0: bb = 16'($urandom_range(0, 5200));
      1: bb = 16'($urandom_range(36000, 38500));
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: ir = 16'(32'(bb / 16'd2) - $urandom_range(0, 3));
      1: ir = 16'((32'(bb) * $urandom_range(50, 61)) / 100);
      2: ir = 16'((32'(bb) * $urandom_range(61, 80)) / 100);
      3: ir = 16'((32'(bb) * $urandom_range(80, 131)) / 100);
      4: ir = 16'((32'(bb) * $urandom_range(0, 50)) / 100);
      default: ir = 16'($urandom);
    endcase
    send_word(bb, ir);
  endtask

  // random burst traffic in the current mode
  task automatic random_traffic(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && n > 0) begin
        random_word();
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
    end
  endtask

  task automatic test_directed();
    send_word(16'd0, 16'd0);
    send_word(16'd0, 16'hffff);
    send_word(16'hffff, 16'd0);
    send_word(16'hffff, 16'hffff);
    send_word(16'd1000, 16'd500);
    send_word(16'd1000, 16'd501);
    send_word(16'd1000, 16'd610);
    send_word(16'd1000, 16'd611);
    send_word(16'd1000, 16'd800);
    send_word(16'd1000, 16'd801);
    send_word(16'd1000, 16'd1300);
    send_word(16'd1000, 16'd1301);
    send_word(16'd1000, 16'd1);
    send_word(16'h5555, 16'h2aaa);
    send_word(16'haaaa, 16'h5555);
  endtask

  task automatic test_limits();
    write_mode(alc_pkg::MODE_HI_14);
    send_word(16'd5047, 16'd5047);
    send_word(16'd5048, 16'd10);
    send_word(16'd10, 16'd5048);
    write_mode(alc_pkg::MODE_LO_101);
    send_word(16'd37177, 16'd100);
    send_word(16'd37178, 16'd100);
    send_word(16'd100, 16'd37178);
    write_mode(alc_pkg::MODE_LO_14);
    send_word(16'd5047, 16'd1);
    send_word(16'd5000, 16'd6400);
  endtask

  task automatic test_modes();
    for (int m = 0; m < 8; m++) begin
      write_mode(3'(m));
      random_traffic(150);
    end
  endtask

  task automatic test_backpressure();
    write_mode(alc_pkg::MODE_LO_402);
    long_hold = 1'b1;
    random_traffic(60);
    long_hold = 1'b0;
    random_traffic(60);
    drain_readings();
  endtask

  initial begin
    for (int i = 0; i <= alc_pkg::POWER_TABLE_ENTRIES; i++) power_curve[i] = curve_point(i);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_limits();
    test_modes();
    test_backpressure();
    drain_readings();
    if (!failed && mismatch_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // receiver stall pattern, with one long hold-off counted here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (long_hold && !hold_taken) begin
      result_stall <= 1'b1;
      hold_left    <= 300;
      hold_taken   <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      result_stall <= ($urandom_range(0, 1) == 1);
    end
  end

  // compare each accepted word with the oldest expected reading
  always @(posedge clk) begin
    reading_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_readings.size() == 0) begin
        failed = 1'b1;
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word lux=%0d", lux_value);
      end else begin
        want = pending_readings.pop_front();
        if (want.lux !== lux_value || want.sat !== status_code) begin
          failed = 1'b1;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp lux=%0d st=%0d got lux=%0d st=%0d",
                     want.lux, want.sat, lux_value, status_code);
        end
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (pending_readings.size() == 0 && !sample_valid) || hold_left != 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/alc_pkg.sv
rtl/core/alc_front.sv
rtl/core/alc_queue.sv
rtl/core/alc_back.sv
rtl/core/ambient_light_lux_conversion.sv
sim/tb.sv
